[rtl/gsr_pkg.sv]
`default_nettype none
// ============================================================================
// gsr_pkg
// Shared types, constants and register codes of the glyph scanline rasterizer.
// ============================================================================
package gsr_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_GLYPH_COLS  = 8;
   localparam int DEF_GLYPH_ROWS  = 16;
   localparam int DEF_GLYPH_SLOTS = 256;
   localparam int DEF_MAX_SCALE   = 3;

   // Fixed limits of a draw
   localparam int LINE_LIMIT   = 48;
   localparam int HEIGHT_LIMIT = 16;
   localparam int ROW_MSB      = 7;   // bit 7 of a row byte is the leftmost pixel
   localparam int ITALIC_DIV_SHIFT = 2;  // italic shear divides by 4

   // Field widths
   localparam int GLYPH_IDX_W  = 8;
   localparam int ROW_IDX_W    = 4;
   localparam int ROW_BITS_W   = 8;
   localparam int COORD_W      = 16;
   localparam int COLOR_W      = 32;
   localparam int SCALE_IN_W   = 2;
   localparam int SCALE_W      = 3;   // holds a scale up to the largest MAX_SCALE
   localparam int PIXEL_MASK_W = 25;
   localparam int LINE_CNT_W   = 6;

   localparam int WIDTH_REG_W  = 4;
   localparam int HEIGHT_REG_W = 5;
   localparam int COUNT_REG_W  = 9;

   localparam int REQ_DATA_W   = 88;
   localparam int REQ_USER_W   = 1;
   localparam int RSP_DATA_W   = 96;

   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   // Item kinds carried in tuser
   localparam logic MODE_DRAW = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   // Register indexes (word address)
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_COUNT  = 2'd2;

   // Reset values
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 4'd8;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 5'd16;
   localparam logic [COUNT_REG_W-1:0]  COUNT_RESET  = 9'd256;

   // Per-draw settings that shape a row mask
   typedef struct packed {
      logic [WIDTH_REG_W-1:0] cols;
      logic [SCALE_W-1:0]     scale;
      logic                   bold;
   } mask_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } seq_state_type;

endpackage
`default_nettype wire

[rtl/glyph_scanline_rasterizer.sv]
`default_nettype none
// ============================================================================
// glyph_scanline_rasterizer
// Glyph store plus a row sequencer that turns a stored glyph into scaled,
// sheared and optionally bold scanlines.
// ============================================================================
//
//   Channel   Dir   Handshake          Moves
//   req_*     in    tvalid/tready      one load (row byte) or draw command
//   rsp_*     out   tvalid/tready      one scanline, tlast on the glyph's last
//   csr_*     in    APB psel/penable   glyph_width, glyph_height, glyph_count
//
// A load writes one byte of the glyph store.
// A draw issues one store read per scanline, one scanline per cycle while
// the rsp side keeps up, for height * scale lines (at most 48); the single
// read port of the store and the row sequencer set that figure. A draw holds
// the command side from its transfer until its last read is issued. The
// first scanline goes through the sequencer state, the store read and the
// output register before it is offered. The next item is taken in the cycle
// after the last read is issued.
// Reset clears control and registers only; the store is undefined until loaded.
// A stalled rsp side holds the output register, then the read stage, then
// the sequencer; nothing is dropped.
//
module glyph_scanline_rasterizer #(
   parameter int GLYPH_COLS  = gsr_pkg::DEF_GLYPH_COLS,
   parameter int GLYPH_ROWS  = gsr_pkg::DEF_GLYPH_ROWS,
   parameter int GLYPH_SLOTS = gsr_pkg::DEF_GLYPH_SLOTS,
   parameter int MAX_SCALE   = gsr_pkg::DEF_MAX_SCALE
) (
   input  logic                            clock,
   input  logic                            reset,
   // command stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // glyph_index, row_index, row_bits, x_origin, y_origin, color, scale,
   // bold, italic
   input  logic [gsr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // mode
   input  logic [gsr_pkg::REQ_USER_W-1:0]  req_tuser,
   // scanline stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // line_x, line_y, pixel_mask, pixel_color, zero padding
   output logic [gsr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gsr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [gsr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [gsr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import gsr_pkg::*;

   localparam int STORE_DEPTH = GLYPH_SLOTS * GLYPH_ROWS;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // ---------------------------------------------------------------------
   // Request fields
   // ---------------------------------------------------------------------
   logic                    req_mode;
   logic [GLYPH_IDX_W-1:0]  req_glyph;
   logic [ROW_IDX_W-1:0]    req_row;
   logic [ROW_BITS_W-1:0]   req_bits;
   logic [COORD_W-1:0]      req_x;
   logic [COORD_W-1:0]      req_y;
   logic [COLOR_W-1:0]      req_color;
   logic [SCALE_IN_W-1:0]   req_scale;
   logic                    req_bold;
   logic                    req_italic;

   assign req_mode   = req_tuser[0];
   assign req_glyph  = req_tdata[7:0];
   assign req_row    = req_tdata[11:8];
   assign req_bits   = req_tdata[19:12];
   assign req_x      = req_tdata[35:20];
   assign req_y      = req_tdata[51:36];
   assign req_color  = req_tdata[83:52];
   assign req_scale  = req_tdata[85:84];
   assign req_bold   = req_tdata[86];
   assign req_italic = req_tdata[87];

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [COUNT_REG_W-1:0]  count_ff;
   logic                    csr_write;
   logic [1:0]              csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         count_ff  <= COUNT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_WIDTH:  width_ff  <= csr_pwdata[WIDTH_REG_W-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[HEIGHT_REG_W-1:0];
            REG_COUNT:  count_ff  <= csr_pwdata[COUNT_REG_W-1:0];
            default: ;  // unmapped word: drop the write
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         REG_COUNT:  csr_prdata = CSR_DATA_W'(count_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Command decode
   // ---------------------------------------------------------------------
   logic                    req_xfer;
   logic                    load_ok;
   logic                    glyph_ok;
   logic [HEIGHT_REG_W-1:0] height_sat;
   logic [WIDTH_REG_W-1:0]  cols_sat;
   logic [SCALE_W-1:0]      scale_sat;
   logic                    draw_start;
   logic                    draw_empty;
   logic                    load_write;
   logic [ADDR_W-1:0]       load_addr;

   assign req_xfer = req_tvalid && req_tready;
   assign load_ok  = (32'(req_glyph) < GLYPH_SLOTS) && (32'(req_row) < GLYPH_ROWS);
   assign glyph_ok = ({1'b0, req_glyph} < count_ff) && (32'(req_glyph) < GLYPH_SLOTS);

   always_comb begin
      height_sat = (32'(height_ff) > HEIGHT_LIMIT) ? HEIGHT_REG_W'(HEIGHT_LIMIT)
                                                   : height_ff;
      cols_sat   = (32'(width_ff) > GLYPH_COLS) ? WIDTH_REG_W'(GLYPH_COLS) : width_ff;
      // scale zero acts as one, above the limit saturates
      if (req_scale == '0) begin
         scale_sat = SCALE_W'(1);
      end else if (32'(req_scale) > MAX_SCALE) begin
         scale_sat = SCALE_W'(MAX_SCALE);
      end else begin
         scale_sat = SCALE_W'(req_scale);
      end
   end

   assign draw_start = req_xfer && (req_mode == MODE_DRAW) && glyph_ok &&
                       (height_sat != '0);
   // a valid draw of zero rows emits nothing but still clears the counter
   assign draw_empty = req_xfer && (req_mode == MODE_DRAW) && glyph_ok &&
                       (height_sat == '0);
   assign load_write = req_xfer && (req_mode == MODE_LOAD) && load_ok;
   assign load_addr  = ADDR_W'(32'(req_glyph) * GLYPH_ROWS + 32'(req_row));

   // ---------------------------------------------------------------------
   // Row sequencer (stage 1): one store read per scanline
   // ---------------------------------------------------------------------
   seq_state_type           state_ff,  state_in;
   logic [ADDR_W-1:0]       base_ff,   base_in;
   logic [ROW_IDX_W-1:0]    gy_ff,     gy_in;
   logic [SCALE_W-1:0]      sy_ff,     sy_in;
   logic [LINE_CNT_W-1:0]   line_cnt_ff, line_cnt_in;   // scanline counter
   logic [HEIGHT_REG_W-1:0] h_ff,      h_in;
   logic [COORD_W-1:0]      x0_ff,     x0_in;
   logic [COORD_W-1:0]      y_ff,      y_in;
   logic [COLOR_W-1:0]      color_ff,  color_in;
   logic                    italic_ff, italic_in;
   mask_ctrl_type           ctrl_ff,   ctrl_in;

   // stage 2: read data plus scanline sidecar
   logic                    s2_valid_ff, s2_valid_in;
   logic [COORD_W-1:0]      s2_x_ff,     s2_x_in;
   logic [COORD_W-1:0]      s2_y_ff,     s2_y_in;
   logic [COLOR_W-1:0]      s2_color_ff, s2_color_in;
   logic                    s2_last_ff,  s2_last_in;
   logic                    s2_zero_ff,  s2_zero_in;
   mask_ctrl_type           s2_ctrl_ff,  s2_ctrl_in;
   logic [ROW_BITS_W-1:0]   rdata_ff;

   // output register
   logic                    out_valid_ff, out_valid_in;
   logic [COORD_W-1:0]      out_x_ff;
   logic [COORD_W-1:0]      out_y_ff;
   logic [PIXEL_MASK_W-1:0] out_mask_ff;
   logic [COLOR_W-1:0]      out_color_ff;
   logic                    out_last_ff;

   logic                    s2_move;
   logic                    issue;
   logic                    row_in_store;
   logic                    line_last;
   logic [ADDR_W-1:0]       rd_addr;
   logic [3:0]              half;
   logic signed [5:0]       shear_diff;
   logic [5:0]              shear_mag;
   logic [3:0]              shear_q;
   logic [COORD_W-1:0]      shear;
   logic [ROW_BITS_W-1:0]   mask_row;
   logic [PIXEL_MASK_W-1:0] mask_val;

   assign s2_move      = s2_valid_ff && (!out_valid_ff || rsp_tready);
   assign issue        = (state_ff == ST_RUN) && (!s2_valid_ff || s2_move);
   assign req_tready   = (state_ff == ST_IDLE);
   assign row_in_store = (32'(gy_ff) < GLYPH_ROWS);
   assign rd_addr      = base_ff + ADDR_W'(gy_ff);
   assign line_last    = ((sy_ff == ctrl_ff.scale - SCALE_W'(1)) &&
                          ({1'b0, gy_ff} == h_ff - HEIGHT_REG_W'(1))) ||
                         (line_cnt_ff == LINE_CNT_W'(LINE_LIMIT - 1));

   // Italic shear: (height/2 - row) / 4, truncated toward zero
   always_comb begin
      half       = h_ff[4:1];
      shear_diff = $signed({2'b00, half}) - $signed({2'b00, gy_ff});
      shear_mag  = shear_diff[5] ? 6'(-shear_diff) : 6'(shear_diff);
      shear_q    = 4'(shear_mag >> ITALIC_DIV_SHIFT);
      if (!italic_ff) begin
         shear = '0;
      end else if (shear_diff[5]) begin
         shear = -COORD_W'(shear_q);
      end else begin
         shear = COORD_W'(shear_q);
      end
   end

   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      gy_in       = gy_ff;
      sy_in       = sy_ff;
      line_cnt_in = line_cnt_ff;
      h_in        = h_ff;
      x0_in       = x0_ff;
      y_in        = y_ff;
      color_in    = color_ff;
      italic_in   = italic_ff;
      ctrl_in     = ctrl_ff;

      if (draw_start) begin
         state_in       = ST_RUN;
         base_in        = ADDR_W'(32'(req_glyph) * GLYPH_ROWS);
         gy_in          = '0;
         sy_in          = '0;
         line_cnt_in    = '0;
         h_in           = height_sat;
         x0_in          = req_x;
         y_in           = req_y;
         color_in       = req_color;
         italic_in      = req_italic;
         ctrl_in.cols   = cols_sat;
         ctrl_in.scale  = scale_sat;
         ctrl_in.bold   = req_bold;
      end else if (draw_empty) begin
         line_cnt_in = '0;
      end else if (issue) begin
         line_cnt_in = line_cnt_ff + LINE_CNT_W'(1);
         y_in        = y_ff + COORD_W'(1);
         // advance sub-row, then glyph row
         if (sy_ff == ctrl_ff.scale - SCALE_W'(1)) begin
            sy_in = '0;
            gy_in = gy_ff + ROW_IDX_W'(1);
         end else begin
            sy_in = sy_ff + SCALE_W'(1);
         end
         if (line_last) begin
            state_in = ST_IDLE;
         end
      end
   end

   // stage 2 next values: capture the sidecar on issue, hold while stalled
   always_comb begin
      s2_x_in     = s2_x_ff;
      s2_y_in     = s2_y_ff;
      s2_color_in = s2_color_ff;
      s2_last_in  = s2_last_ff;
      s2_zero_in  = s2_zero_ff;
      s2_ctrl_in  = s2_ctrl_ff;
      if (issue) begin
         s2_valid_in = 1'b1;
         s2_x_in     = x0_ff + shear;
         s2_y_in     = y_ff;
         s2_color_in = color_ff;
         s2_last_in  = line_last;
         s2_zero_in  = !row_in_store;
         s2_ctrl_in  = ctrl_ff;
      end else if (s2_move) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end

      if (s2_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         line_cnt_ff  <= '0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         line_cnt_ff  <= line_cnt_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      gy_ff       <= gy_in;
      sy_ff       <= sy_in;
      h_ff        <= h_in;
      x0_ff       <= x0_in;
      y_ff        <= y_in;
      color_ff    <= color_in;
      italic_ff   <= italic_in;
      ctrl_ff     <= ctrl_in;
      s2_x_ff     <= s2_x_in;
      s2_y_ff     <= s2_y_in;
      s2_color_ff <= s2_color_in;
      s2_last_ff  <= s2_last_in;
      s2_zero_ff  <= s2_zero_in;
      s2_ctrl_ff  <= s2_ctrl_in;
   end

   // ---------------------------------------------------------------------
   // Glyph store: one write port (loads), one registered read port (draws).
   // Loads are only taken while the sequencer is idle, so the ports never
   // touch the same entry in one cycle.
   // ---------------------------------------------------------------------
   logic [ROW_BITS_W-1:0] glyph_store_ff [STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (load_write) begin
         glyph_store_ff[load_addr] <= req_bits;
      end
      if (issue && row_in_store) begin
         rdata_ff <= glyph_store_ff[rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Mask expansion and output register
   // ---------------------------------------------------------------------
   // rows beyond the store read as blank
   assign mask_row = s2_zero_ff ? '0 : rdata_ff;

   gsr_mask_unit #(
      .GLYPH_COLS (GLYPH_COLS),
      .MAX_SCALE  (MAX_SCALE)
   ) u_mask (
      .row_bits   (mask_row),
      .ctrl       (s2_ctrl_ff),
      .pixel_mask (mask_val)
   );

   always_ff @(posedge clock) begin
      if (s2_move) begin
         out_x_ff     <= s2_x_ff;
         out_y_ff     <= s2_y_ff;
         out_mask_ff  <= mask_val;
         out_color_ff <= s2_color_ff;
         out_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {7'b0, out_color_ff, out_mask_ff, out_y_ff, out_x_ff};

endmodule
`default_nettype wire

[rtl/gsr_mask_unit.sv]
`default_nettype none
// ============================================================================
// gsr_mask_unit
// Expands one glyph row byte into a scanline pixel mask: each used column is
// repeated scale times, leftmost pixel into bit zero, then bold smear.
// ============================================================================
module gsr_mask_unit #(
   parameter int GLYPH_COLS = gsr_pkg::DEF_GLYPH_COLS,
   parameter int MAX_SCALE  = gsr_pkg::DEF_MAX_SCALE
) (
   input  logic [gsr_pkg::ROW_BITS_W-1:0]   row_bits,
   input  gsr_pkg::mask_ctrl_type           ctrl,
   output logic [gsr_pkg::PIXEL_MASK_W-1:0] pixel_mask
);
   import gsr_pkg::*;

   localparam int RAW_W = GLYPH_COLS * MAX_SCALE + 1;
   localparam int EXT_W = (RAW_W > PIXEL_MASK_W) ? RAW_W : PIXEL_MASK_W;

   logic [EXT_W-1:0] cand [1:MAX_SCALE];
   logic [EXT_W-1:0] raw;
   logic [EXT_W-1:0] smeared;

   // One candidate per scale value, all with fixed bit positions
   always_comb begin
      for (int s = 1; s <= MAX_SCALE; s++) begin
         cand[s] = '0;
         for (int gx = 0; gx < GLYPH_COLS; gx++) begin
            for (int k = 0; k < s; k++) begin
               cand[s][gx*s + k] = row_bits[ROW_MSB - gx] &&
                                   (WIDTH_REG_W'(gx) < ctrl.cols);
            end
         end
      end
   end

   always_comb begin
      raw = '0;
      for (int s = 1; s <= MAX_SCALE; s++) begin
         if (ctrl.scale == SCALE_W'(s)) begin
            raw = cand[s];
         end
      end
      smeared = ctrl.bold ? (raw | (raw << 1)) : raw;
   end

   assign pixel_mask = smeared[PIXEL_MASK_W-1:0];

endmodule
`default_nettype wire

[rtl/gsr_checker.sv]
`default_nettype none
// ============================================================================
// gsr_checker
// Port-level checks on the glyph scanline rasterizer, bound to the top level.
// ============================================================================
module gsr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [gsr_pkg::REQ_USER_W-1:0]  req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gsr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            csr_pready
);
   import gsr_pkg::*;

   // A stalled scanline transfer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // No scanline is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // A load never occupies the sequencer
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == MODE_LOAD) |=> req_tready)
      else $error("ready dropped after a load transfer");

   // Register port never waits
   a_pready: assert property (@(posedge clock)
      csr_pready)
      else $error("csr_pready low");

endmodule

bind glyph_scanline_rasterizer gsr_checker u_gsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);
`default_nettype wire
